// ===== rtl/tcw_pkg.sv =====
// Package for the text console writer: grid geometry, payload structs,
// command codes and the controller-to-datapath command and status types.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    // Grid geometry.
    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int TOTAL_CELLS = COLUMNS * ROWS;

    localparam int POS_W = (TOTAL_CELLS > 1) ? $clog2(TOTAL_CELLS) : 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [ROW_W-1:0] row_t;
    typedef logic [COL_W-1:0] col_t;

    // Fixed field widths of the result payload.
    typedef logic [10:0] out_pos_t;
    typedef logic [4:0]  out_row_t;
    typedef logic [6:0]  out_col_t;

    // Character and attribute constants.
    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] RESET_ATTR   = 8'h07;

    // Command codes of an input transaction.
    typedef enum logic [1:0] {
        CMD_PUT       = 2'd0,
        CMD_BACKSPACE = 2'd1,
        CMD_CLEAR     = 2'd2,
        CMD_READ      = 2'd3
    } cmd_code_t;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  character;
        logic [7:0]  attribute;
        logic [10:0] cell_index;
    } item_t;

    // Result transaction payload.
    typedef struct packed {
        out_pos_t    cursor_position;
        out_row_t    cursor_row;
        out_col_t    cursor_column;
        logic [7:0]  read_character;
        logic [7:0]  read_attribute;
        logic        scrolled;
    } result_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_PUT,
        DP_NEWLINE,
        DP_COPY_RD,
        DP_COPY_WR,
        DP_FILL,
        DP_BS_RD,
        DP_BS_WR,
        DP_HOME,
        DP_CELL_RD,
        DP_CELL_CAP,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   mark_scroll;
        logic   reset_attr;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] command;
        logic       is_newline;
        logic       cursor_zero;
        logic       last_row;
        logic       last_col;
        logic       idx_in_range;
        logic       ptr_copy_last;
        logic       ptr_last;
    } dp_status_t;

endpackage

// ===== rtl/tcw_datapath.sv =====
// Datapath of the text console writer: cell memory, cursor, sweep pointer,
// default attribute register and result register.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  tcw_pkg::item_t     item,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  tcw_pkg::dp_cmd_t   cmd,
    output tcw_pkg::dp_status_t status,
    output tcw_pkg::result_t   result
);

    localparam tcw_pkg::pos_t LAST_ROW_START =
        tcw_pkg::pos_t'((tcw_pkg::ROWS - 1) * tcw_pkg::COLUMNS);
    localparam tcw_pkg::pos_t LAST_CELL  = tcw_pkg::pos_t'(tcw_pkg::TOTAL_CELLS - 1);
    localparam tcw_pkg::pos_t COPY_LAST  =
        tcw_pkg::pos_t'(tcw_pkg::TOTAL_CELLS - tcw_pkg::COLUMNS - 1);
    localparam tcw_pkg::pos_t ROW_STRIDE = tcw_pkg::pos_t'(tcw_pkg::COLUMNS);
    localparam tcw_pkg::row_t LAST_ROW   = tcw_pkg::row_t'(tcw_pkg::ROWS - 1);
    localparam tcw_pkg::col_t LAST_COL   = tcw_pkg::col_t'(tcw_pkg::COLUMNS - 1);

    logic [15:0]      mem [tcw_pkg::TOTAL_CELLS];
    logic [15:0]      rdata_reg;
    logic             mem_we;
    tcw_pkg::pos_t    mem_waddr;
    logic [15:0]      mem_wdata;
    tcw_pkg::pos_t    mem_raddr;

    tcw_pkg::item_t   item_reg;
    logic             scroll_reg;
    logic [15:0]      rdval_reg;
    tcw_pkg::result_t result_reg;
    logic [7:0]       attr_reg;

    tcw_pkg::pos_t    pos_reg, pos_next;
    tcw_pkg::row_t    row_reg, row_next;
    tcw_pkg::col_t    col_reg, col_next;
    tcw_pkg::pos_t    ptr_reg, ptr_next;

    logic             last_row;
    logic             last_col;
    logic             idx_in_range;
    logic [7:0]       fill_attr;

    assign last_row     = (row_reg == LAST_ROW);
    assign last_col     = (col_reg == LAST_COL);
    assign idx_in_range = (32'(item_reg.cell_index) < tcw_pkg::TOTAL_CELLS);
    assign fill_attr    = cmd.reset_attr ? tcw_pkg::RESET_ATTR : attr_reg;

    // Status back to the controller.
    always_comb
    begin
        status.command       = item_reg.command;
        status.is_newline    = (item_reg.character == tcw_pkg::NEWLINE_CHAR);
        status.cursor_zero   = (pos_reg == '0);
        status.last_row      = last_row;
        status.last_col      = last_col;
        status.idx_in_range  = idx_in_range;
        status.ptr_copy_last = (ptr_reg == COPY_LAST);
        status.ptr_last      = (ptr_reg == LAST_CELL);
    end

    // Memory port selection for each operation.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = {item_reg.attribute, item_reg.character};
        mem_raddr = pos_reg;
        case (cmd.op)
            tcw_pkg::DP_PUT:
            begin
                mem_we = 1'b1;
            end
            tcw_pkg::DP_COPY_RD:
            begin
                mem_raddr = tcw_pkg::pos_t'(ptr_reg + ROW_STRIDE);
            end
            tcw_pkg::DP_COPY_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = rdata_reg;
            end
            tcw_pkg::DP_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = {fill_attr, tcw_pkg::SPACE_CHAR};
            end
            tcw_pkg::DP_BS_RD:
            begin
                mem_raddr = tcw_pkg::pos_t'(pos_reg - 1'b1);
            end
            tcw_pkg::DP_BS_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {rdata_reg[15:8], tcw_pkg::SPACE_CHAR};
            end
            tcw_pkg::DP_CELL_RD:
            begin
                mem_raddr = tcw_pkg::pos_t'(item_reg.cell_index);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Cell memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Cursor and sweep pointer updates.
    always_comb
    begin
        pos_next = pos_reg;
        row_next = row_reg;
        col_next = col_reg;
        ptr_next = ptr_reg;
        case (cmd.op)
            tcw_pkg::DP_LOAD:
            begin
                ptr_next = '0;
            end
            tcw_pkg::DP_PUT:
            begin
                if (last_col && last_row)
                begin
                    pos_next = LAST_ROW_START;
                    col_next = '0;
                end
                else if (last_col)
                begin
                    pos_next = tcw_pkg::pos_t'(pos_reg + 1'b1);
                    row_next = tcw_pkg::row_t'(row_reg + 1'b1);
                    col_next = '0;
                end
                else
                begin
                    pos_next = tcw_pkg::pos_t'(pos_reg + 1'b1);
                    col_next = tcw_pkg::col_t'(col_reg + 1'b1);
                end
            end
            tcw_pkg::DP_NEWLINE:
            begin
                col_next = '0;
                if (last_row)
                begin
                    pos_next = LAST_ROW_START;
                end
                else
                begin
                    pos_next = tcw_pkg::pos_t'(pos_reg + ROW_STRIDE
                                               - tcw_pkg::pos_t'(col_reg));
                    row_next = tcw_pkg::row_t'(row_reg + 1'b1);
                end
            end
            tcw_pkg::DP_COPY_WR, tcw_pkg::DP_FILL:
            begin
                ptr_next = tcw_pkg::pos_t'(ptr_reg + 1'b1);
            end
            tcw_pkg::DP_BS_RD:
            begin
                pos_next = tcw_pkg::pos_t'(pos_reg - 1'b1);
                if (col_reg == '0)
                begin
                    col_next = LAST_COL;
                    row_next = tcw_pkg::row_t'(row_reg - 1'b1);
                end
                else
                begin
                    col_next = tcw_pkg::col_t'(col_reg - 1'b1);
                end
            end
            tcw_pkg::DP_HOME:
            begin
                pos_next = '0;
                row_next = '0;
                col_next = '0;
                ptr_next = '0;
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    // Cursor, pointer and default attribute registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            ptr_reg  <= '0;
            attr_reg <= tcw_pkg::RESET_ATTR;
        end
        else
        begin
            pos_reg <= pos_next;
            row_reg <= row_next;
            col_reg <= col_next;
            ptr_reg <= ptr_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    // Transaction payload, read value, scroll flag and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.op == tcw_pkg::DP_LOAD)
        begin
            item_reg   <= item;
            scroll_reg <= 1'b0;
            rdval_reg  <= '0;
        end
        else if (cmd.mark_scroll)
        begin
            scroll_reg <= 1'b1;
        end
        if (cmd.op == tcw_pkg::DP_CELL_CAP)
        begin
            rdval_reg <= rdata_reg;
        end
        if (cmd.op == tcw_pkg::DP_RESULT)
        begin
            result_reg.cursor_position <= tcw_pkg::out_pos_t'(pos_reg);
            result_reg.cursor_row      <= tcw_pkg::out_row_t'(row_reg);
            result_reg.cursor_column   <= tcw_pkg::out_col_t'(col_reg);
            result_reg.read_character  <= rdval_reg[7:0];
            result_reg.read_attribute  <= rdval_reg[15:8];
            result_reg.scrolled        <= scroll_reg;
        end
    end

    assign result = result_reg;

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Controller of the text console writer: sequences each command, the
// scroll copy, the grid fill passes and the input and result handshakes.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    output logic                result_valid,
    input  logic                result_ready,
    input  tcw_pkg::dp_status_t status,
    output tcw_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_INIT_FILL,
        ST_IDLE,
        ST_DECODE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_FILL,
        ST_BS_WR,
        ST_READ_CAP,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   result_valid_reg, result_valid_next;
    logic   result_load;

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result_load  = (state_reg == ST_FINISH) && (!result_valid_reg || result_ready);

    // Next state and datapath command.
    always_comb
    begin
        state_next      = state_reg;
        cmd.op          = tcw_pkg::DP_NOP;
        cmd.mark_scroll = 1'b0;
        cmd.reset_attr  = 1'b0;
        case (state_reg)
            ST_INIT_FILL:
            begin
                cmd.op         = tcw_pkg::DP_FILL;
                cmd.reset_attr = 1'b1;
                if (status.ptr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.op     = tcw_pkg::DP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_FINISH;
                case (status.command)
                    tcw_pkg::CMD_PUT:
                    begin
                        if (status.is_newline)
                        begin
                            cmd.op = tcw_pkg::DP_NEWLINE;
                            if (status.last_row)
                            begin
                                cmd.mark_scroll = 1'b1;
                                state_next      = ST_COPY_RD;
                            end
                        end
                        else
                        begin
                            cmd.op = tcw_pkg::DP_PUT;
                            if (status.last_row && status.last_col)
                            begin
                                cmd.mark_scroll = 1'b1;
                                state_next      = ST_COPY_RD;
                            end
                        end
                    end
                    tcw_pkg::CMD_BACKSPACE:
                    begin
                        if (!status.cursor_zero)
                        begin
                            cmd.op     = tcw_pkg::DP_BS_RD;
                            state_next = ST_BS_WR;
                        end
                    end
                    tcw_pkg::CMD_CLEAR:
                    begin
                        cmd.op     = tcw_pkg::DP_HOME;
                        state_next = ST_FILL;
                    end
                    default:
                    begin
                        if (status.idx_in_range)
                        begin
                            cmd.op     = tcw_pkg::DP_CELL_RD;
                            state_next = ST_READ_CAP;
                        end
                    end
                endcase
            end
            ST_COPY_RD:
            begin
                cmd.op     = tcw_pkg::DP_COPY_RD;
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                cmd.op     = tcw_pkg::DP_COPY_WR;
                state_next = status.ptr_copy_last ? ST_FILL : ST_COPY_RD;
            end
            ST_FILL:
            begin
                cmd.op = tcw_pkg::DP_FILL;
                if (status.ptr_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_BS_WR:
            begin
                cmd.op     = tcw_pkg::DP_BS_WR;
                state_next = ST_FINISH;
            end
            ST_READ_CAP:
            begin
                cmd.op     = tcw_pkg::DP_CELL_CAP;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (result_load)
                begin
                    cmd.op     = tcw_pkg::DP_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag: set when a result loads, cleared when taken.
    always_comb
    begin
        if (result_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT_FILL;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

endmodule

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: joins the controller and datapath.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
`timescale 1ns / 1ps

// Text console writer. Keeps an 80 x 25 grid of 16-bit cells (attribute in
// the high byte, character in the low byte) in a single-port-write memory,
// plus a cursor. After reset the block fills all TOTAL_CELLS (2000) cells
// with spaces in attribute 7 before item_ready rises; configuration writes
// are taken during that time. One transaction is worked at a time. A put or
// newline that does not scroll, an out-of-range read or a backspace at cell
// zero goes from the decode state straight to the finish state, where the
// result register loads before the return to idle; an in-range read or a
// backspace first passes through the read capture or backspace write state,
// since it waits on the registered memory read. A clear writes every cell
// once through the memory write port. A scroll copies each cell up one row
// with a read step and a write step, then blanks the last row. The result
// register lets the next transaction be accepted while a result still waits
// on result_ready; that transaction then holds in its last state until the
// waiting result is taken.

module text_console_writer (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  tcw_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output tcw_pkg::result_t result,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_wdata
);

    tcw_pkg::dp_cmd_t    cmd;
    tcw_pkg::dp_status_t status;

    // Sequencer.
    tcw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // Grid memory, cursor and result storage.
    tcw_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule
